[design/wpsd_pkg.sv]
// Shared constants, types and control codes of the windowed position stillness detector.
// Every module of the block takes its widths and codes from here; the package depends on nothing.
`default_nettype none

package wpsd_pkg;

  // Window length and coordinate format.
  localparam int WINDOW = 16;
  localparam int CW     = 16;
  localparam int LOG_W  = $clog2(WINDOW);
  localparam int FILL_W = $clog2(WINDOW + 1);
  localparam int ROT_W  = (LOG_W < 1) ? 1 : LOG_W;

  // Per-axis datapath widths. The sum holds WINDOW coordinates, the deviation
  // WINDOW*p - S stays below WINDOW*2^CW in magnitude.
  localparam int SUM_W  = CW + LOG_W;
  localparam int DIFF_W = CW + LOG_W + 1;
  localparam int MAG_W  = CW + LOG_W;
  localparam int SQ_W   = 2 * MAG_W;
  localparam int D_W    = SQ_W + LOG_W;

  // Threshold, scaled threshold and the wide multiply-accumulate.
  localparam int MV_W     = 24;
  localparam int MV_RESET = 400;
  localparam int W3       = WINDOW * WINDOW * WINDOW;
  localparam int T_W      = MV_W + 3 * LOG_W;
  localparam int MUL_W    = (D_W + 1) / 2;
  localparam int OPND_W   = 2 * MUL_W;
  localparam int PROD_W   = 2 * MUL_W;
  localparam int ACC_W    = 2 * D_W + 2;

  // Operand selection for the shared multiplier.
  localparam logic [1:0] OP_X   = 2'd0;
  localparam logic [1:0] OP_Y   = 2'd1;
  localparam logic [1:0] OP_Z   = 2'd2;
  localparam logic [1:0] OP_LIM = 2'd3;

  // Partial products of a split square.
  localparam logic [1:0] PART_LO  = 2'd0;
  localparam logic [1:0] PART_MID = 2'd1;
  localparam logic [1:0] PART_HI  = 2'd2;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } point_t;

  typedef struct packed {
    logic push;
    logic evict;
    logic tap_valid;
  } lane_ctrl_t;

  typedef struct packed {
    logic       clear;
    logic       issue;
    logic [1:0] operand;
    logic [1:0] part;
  } mac_ctrl_t;

endpackage

`default_nettype wire

[design/wpsd_cell.sv]
// One cell of the point window chain: holds a single 3D point.
// Uses point_t from wpsd_pkg.
`default_nettype none

module wpsd_cell (
  input  wire                      clk,
  input  wire                      shift,
  input  wire wpsd_pkg::point_t    d_in,
  output wpsd_pkg::point_t         q
);

  wpsd_pkg::point_t pt;

  always_ff @(posedge clk) begin
    if (shift) begin
      pt <= d_in;
    end
  end

  assign q = pt;

endmodule

`default_nettype wire

[design/wpsd_lane.sv]
// One axis lane: running sum of the window and the spread D = sum of (WINDOW*p - S)^2.
// Widths and control struct come from wpsd_pkg.
`default_nettype none

module wpsd_lane (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire wpsd_pkg::lane_ctrl_t           ctrl,
  input  wire signed [wpsd_pkg::CW-1:0]       new_coord,
  input  wire signed [wpsd_pkg::CW-1:0]       oldest,
  output logic [wpsd_pkg::D_W-1:0]            spread
);

  logic signed [wpsd_pkg::SUM_W-1:0]  sum;
  logic signed [wpsd_pkg::SUM_W-1:0]  sum_next;
  logic signed [wpsd_pkg::SUM_W-1:0]  evict_term;
  logic signed [wpsd_pkg::DIFF_W-1:0] tap_ext;
  logic signed [wpsd_pkg::DIFF_W-1:0] sum_ext;
  logic signed [wpsd_pkg::DIFF_W-1:0] scaled;
  logic signed [wpsd_pkg::DIFF_W-1:0] diff;
  logic signed [wpsd_pkg::DIFF_W-1:0] diff_neg;
  logic [wpsd_pkg::MAG_W-1:0]         mag;
  logic [wpsd_pkg::MAG_W-1:0]         mag_next;
  logic                               mag_valid;
  logic [wpsd_pkg::SQ_W-1:0]          sq;
  logic [wpsd_pkg::SQ_W-1:0]          sq_next;
  logic                               sq_valid;

  // The oldest point leaves the sum only once the window is full.
  assign evict_term = ctrl.evict ? wpsd_pkg::SUM_W'(oldest) : wpsd_pkg::SUM_W'(0);
  assign sum_next   = sum + wpsd_pkg::SUM_W'(new_coord) - evict_term;

  assign tap_ext  = wpsd_pkg::DIFF_W'(oldest);
  assign sum_ext  = wpsd_pkg::DIFF_W'(sum);
  assign scaled   = tap_ext * wpsd_pkg::DIFF_W'(wpsd_pkg::WINDOW);
  assign diff     = scaled - sum_ext;
  assign diff_neg = -diff;
  assign mag_next = diff[wpsd_pkg::DIFF_W-1] ? diff_neg[wpsd_pkg::MAG_W-1:0]
                                             : diff[wpsd_pkg::MAG_W-1:0];
  assign sq_next  = wpsd_pkg::SQ_W'(mag) * wpsd_pkg::SQ_W'(mag);

  always_ff @(posedge clk) begin
    if (rst) begin
      sum       <= '0;
      mag_valid <= 1'b0;
      sq_valid  <= 1'b0;
    end else begin
      if (ctrl.push) begin
        sum <= sum_next;
      end
      mag_valid <= ctrl.tap_valid;
      sq_valid  <= mag_valid;
    end
  end

  always_ff @(posedge clk) begin
    mag <= mag_next;
    sq  <= sq_next;
    if (ctrl.push) begin
      spread <= '0;
    end else if (sq_valid) begin
      spread <= spread + wpsd_pkg::D_W'(sq);
    end
  end

endmodule

`default_nettype wire

[design/wpsd_mac.sv]
// Shared split multiplier that squares the three spreads and the scaled threshold,
// accumulates both sides and compares them. Widths and codes come from wpsd_pkg.
`default_nettype none

module wpsd_mac (
  input  wire                         clk,
  input  wire                         rst,
  input  wire wpsd_pkg::mac_ctrl_t    ctrl,
  input  wire [wpsd_pkg::MV_W-1:0]    threshold,
  input  wire [wpsd_pkg::D_W-1:0]     d_x,
  input  wire [wpsd_pkg::D_W-1:0]     d_y,
  input  wire [wpsd_pkg::D_W-1:0]     d_z,
  output logic                        below
);

  logic [wpsd_pkg::T_W-1:0]    t_scaled;
  logic [wpsd_pkg::OPND_W-1:0] opnd;
  logic [wpsd_pkg::MUL_W-1:0]  opnd_lo;
  logic [wpsd_pkg::MUL_W-1:0]  opnd_hi;
  logic [wpsd_pkg::MUL_W-1:0]  fa;
  logic [wpsd_pkg::MUL_W-1:0]  fb;
  logic [wpsd_pkg::PROD_W-1:0] prod;
  logic                        prod_valid;
  logic                        prod_lim;
  logic [1:0]                  prod_part;
  logic [wpsd_pkg::ACC_W-1:0]  prod_ext;
  logic [wpsd_pkg::ACC_W-1:0]  shifted;
  logic [wpsd_pkg::ACC_W-1:0]  tot_acc;
  logic [wpsd_pkg::ACC_W-1:0]  lim_acc;

  always_comb begin
    case (ctrl.operand)
      wpsd_pkg::OP_X:   opnd = wpsd_pkg::OPND_W'(d_x);
      wpsd_pkg::OP_Y:   opnd = wpsd_pkg::OPND_W'(d_y);
      wpsd_pkg::OP_Z:   opnd = wpsd_pkg::OPND_W'(d_z);
      wpsd_pkg::OP_LIM: opnd = wpsd_pkg::OPND_W'(t_scaled);
      default:          opnd = '0;
    endcase
  end

  assign opnd_lo = opnd[wpsd_pkg::MUL_W-1:0];
  assign opnd_hi = opnd[wpsd_pkg::OPND_W-1:wpsd_pkg::MUL_W];

  // A^2 = hi^2 << 2M + (hi*lo) << (M+1) + lo^2, one partial product per step.
  always_comb begin
    case (ctrl.part)
      wpsd_pkg::PART_LO: begin
        fa = opnd_lo;
        fb = opnd_lo;
      end
      wpsd_pkg::PART_MID: begin
        fa = opnd_hi;
        fb = opnd_lo;
      end
      wpsd_pkg::PART_HI: begin
        fa = opnd_hi;
        fb = opnd_hi;
      end
      default: begin
        fa = '0;
        fb = '0;
      end
    endcase
  end

  assign prod_ext = wpsd_pkg::ACC_W'(prod);

  always_comb begin
    case (prod_part)
      wpsd_pkg::PART_LO:  shifted = prod_ext;
      wpsd_pkg::PART_MID: shifted = prod_ext << (wpsd_pkg::MUL_W + 1);
      wpsd_pkg::PART_HI:  shifted = prod_ext << (2 * wpsd_pkg::MUL_W);
      default:            shifted = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else begin
      prod_valid <= ctrl.issue && !ctrl.clear;
    end
  end

  always_ff @(posedge clk) begin
    prod      <= wpsd_pkg::PROD_W'(fa) * wpsd_pkg::PROD_W'(fb);
    prod_part <= ctrl.part;
    prod_lim  <= (ctrl.operand == wpsd_pkg::OP_LIM);
    if (ctrl.clear) begin
      t_scaled <= wpsd_pkg::T_W'(threshold) * wpsd_pkg::T_W'(wpsd_pkg::W3);
      tot_acc  <= '0;
      lim_acc  <= '0;
    end else if (prod_valid) begin
      if (prod_lim) begin
        lim_acc <= lim_acc + shifted;
      end else begin
        tot_acc <= tot_acc + shifted;
      end
    end
  end

  assign below = (tot_acc < lim_acc);

endmodule

`default_nettype wire

[design/windowed_position_stillness_detector_top.sv]
// Top level of the windowed position stillness detector: cell chain, three axis lanes,
// shared multiplier and the sequencer. Depends on wpsd_pkg, wpsd_cell, wpsd_lane, wpsd_mac.
`default_nettype none

// The block takes one 3D point per transfer and returns one result per point. It keeps the
// last WINDOW points in a chain of cells and a running sum per axis. While the window is
// still filling, a point goes from its load straight to the result register, and the
// result carries steady = 0 and window_full = 0. Once WINDOW points have arrived, a
// point goes through these steps in order: it is loaded, the chain rotates once and
// streams every held point through the per-axis square-and-add lanes, those lanes
// drain, the shared split multiplier walks twelve steps (three partial products for
// each of the three spreads and for the scaled threshold), the last accumulation
// settles and the compare result is registered. The next point is taken in the
// cycle after that, even while the previous result still waits in the
// output register. steady is 1 when the sum of the squared per-axis spreads is strictly
// below the squared threshold max_variance * WINDOW^3, so a threshold of zero never reports
// steady. The threshold register resets to 400 and is written through its own channel,
// which is always ready; it must be written only while no point is in flight.

module windowed_position_stillness_detector_top (
  input  wire                          clk,
  input  wire                          rst,
  // Point channel.
  input  wire                          point_valid,
  output logic                         point_stall,
  input  wire signed [wpsd_pkg::CW-1:0] x_pos,
  input  wire signed [wpsd_pkg::CW-1:0] y_pos,
  input  wire signed [wpsd_pkg::CW-1:0] z_pos,
  // Result channel.
  output logic                         result_valid,
  input  wire                          result_stall,
  output logic                         steady,
  output logic                         window_full,
  // Threshold write channel.
  input  wire                          cfg_valid,
  output logic                         cfg_ready,
  input  wire [wpsd_pkg::MV_W-1:0]     max_variance
);

  // Sequencer states.
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_ROTATE = 3'd1;
  localparam logic [2:0] ST_DRAIN  = 3'd2;
  localparam logic [2:0] ST_MAC    = 3'd3;
  localparam logic [2:0] ST_SETTLE = 3'd4;
  localparam logic [2:0] ST_DONE   = 3'd5;

  logic [2:0]                    state;
  logic [wpsd_pkg::ROT_W-1:0]    cnt;
  logic [1:0]                    op_sel;
  logic [1:0]                    part_sel;
  logic [wpsd_pkg::FILL_W-1:0]   fill_count;
  logic [wpsd_pkg::MV_W-1:0]     threshold;

  logic                          push;
  logic                          full;
  logic                          will_full;
  logic                          rotate;
  logic                          load_result;
  logic                          below;

  wpsd_pkg::point_t              new_point;
  wpsd_pkg::point_t              link [wpsd_pkg::WINDOW+1];
  wpsd_pkg::point_t              oldest;
  wpsd_pkg::lane_ctrl_t          lane_ctrl;
  wpsd_pkg::mac_ctrl_t           mac_ctrl;

  logic [wpsd_pkg::D_W-1:0]      d_x;
  logic [wpsd_pkg::D_W-1:0]      d_y;
  logic [wpsd_pkg::D_W-1:0]      d_z;

  // A point is taken only when the sequencer is idle.
  assign point_stall = (state != ST_IDLE);
  assign push        = point_valid && (state == ST_IDLE);
  assign full        = (fill_count == wpsd_pkg::FILL_W'(wpsd_pkg::WINDOW));
  assign will_full   = full || (fill_count == wpsd_pkg::FILL_W'(wpsd_pkg::WINDOW - 1));
  assign rotate      = (state == ST_ROTATE);
  assign load_result = (state == ST_DONE) && (!result_valid || !result_stall);

  // The threshold channel never pushes back.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= wpsd_pkg::MV_W'(wpsd_pkg::MV_RESET);
    end else if (cfg_valid && cfg_ready) begin
      threshold <= max_variance;
    end
  end

  // The chain head takes the new point on a transfer, and the tail's point while the
  // chain rotates, so after a full rotation every point is back in its own cell.
  // Outside rotation, the tail of a full window holds its oldest point.
  assign new_point.x = x_pos;
  assign new_point.y = y_pos;
  assign new_point.z = z_pos;
  assign link[0]     = rotate ? link[wpsd_pkg::WINDOW] : new_point;
  assign oldest      = link[wpsd_pkg::WINDOW];

  for (genvar i = 0; i < wpsd_pkg::WINDOW; i++) begin : g_cell
    wpsd_cell u_cell (
      .clk   (clk),
      .shift (push || rotate),
      .d_in  (link[i]),
      .q     (link[i+1])
    );
  end

  assign lane_ctrl.push      = push;
  assign lane_ctrl.evict     = push && full;
  assign lane_ctrl.tap_valid = rotate;

  wpsd_lane u_lane_x (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (lane_ctrl),
    .new_coord (x_pos),
    .oldest    (oldest.x),
    .spread    (d_x)
  );

  wpsd_lane u_lane_y (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (lane_ctrl),
    .new_coord (y_pos),
    .oldest    (oldest.y),
    .spread    (d_y)
  );

  wpsd_lane u_lane_z (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (lane_ctrl),
    .new_coord (z_pos),
    .oldest    (oldest.z),
    .spread    (d_z)
  );

  assign mac_ctrl.clear   = push;
  assign mac_ctrl.issue   = (state == ST_MAC);
  assign mac_ctrl.operand = op_sel;
  assign mac_ctrl.part    = part_sel;

  wpsd_mac u_mac (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (mac_ctrl),
    .threshold (threshold),
    .d_x       (d_x),
    .d_y       (d_y),
    .d_z       (d_z),
    .below     (below)
  );

  // Sequencer: load, rotate the chain, drain the lanes, walk the twelve multiplier steps,
  // settle the last sum, register the result; a filling window skips from load to result.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      cnt        <= '0;
      op_sel     <= wpsd_pkg::OP_X;
      part_sel   <= wpsd_pkg::PART_LO;
      fill_count <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (push) begin
            if (!full) begin
              fill_count <= fill_count + wpsd_pkg::FILL_W'(1);
            end
            cnt   <= '0;
            state <= will_full ? ST_ROTATE : ST_DONE;
          end
        end
        ST_ROTATE: begin
          if (cnt == wpsd_pkg::ROT_W'(wpsd_pkg::WINDOW - 1)) begin
            cnt   <= '0;
            state <= ST_DRAIN;
          end else begin
            cnt <= cnt + wpsd_pkg::ROT_W'(1);
          end
        end
        ST_DRAIN: begin
          if (cnt == wpsd_pkg::ROT_W'(1)) begin
            cnt      <= '0;
            op_sel   <= wpsd_pkg::OP_X;
            part_sel <= wpsd_pkg::PART_LO;
            state    <= ST_MAC;
          end else begin
            cnt <= cnt + wpsd_pkg::ROT_W'(1);
          end
        end
        ST_MAC: begin
          case (part_sel)
            wpsd_pkg::PART_LO:  part_sel <= wpsd_pkg::PART_MID;
            wpsd_pkg::PART_MID: part_sel <= wpsd_pkg::PART_HI;
            default: begin
              part_sel <= wpsd_pkg::PART_LO;
              case (op_sel)
                wpsd_pkg::OP_X: op_sel <= wpsd_pkg::OP_Y;
                wpsd_pkg::OP_Y: op_sel <= wpsd_pkg::OP_Z;
                wpsd_pkg::OP_Z: op_sel <= wpsd_pkg::OP_LIM;
                default:        state  <= ST_SETTLE;
              endcase
            end
          endcase
        end
        ST_SETTLE: begin
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (load_result) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Output register. It frees up as soon as the downstream side takes the result, so a
  // new point can be worked on while the last result waits.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_result) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_result) begin
      steady      <= full && below;
      window_full <= full;
    end
  end

`ifndef SYNTHESIS
  // The fill count saturates at the window length.
  assert property (@(posedge clk) disable iff (rst)
    fill_count <= wpsd_pkg::FILL_W'(wpsd_pkg::WINDOW))
    else $error("fill count exceeds the window length");

  // Once full, the window stays full until reset.
  assert property (@(posedge clk) disable iff (rst)
    full |=> full)
    else $error("window left the full condition");

  // The chain rotates only over a full window, so no unwritten cell is ever read.
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_ROTATE) |-> full)
    else $error("chain rotation over a partly filled window");

  // A steady result is only ever reported for a full window.
  assert property (@(posedge clk) disable iff (rst)
    (result_valid && steady) |-> window_full)
    else $error("steady reported without a full window");
`endif

endmodule

`default_nettype wire

[tb/sv/stillness_verdict_check.sv]
// Checker for the windowed position stillness detector: watches the point, result and
// threshold channels, predicts each result and compares it. Depends on wpsd_pkg.

module stillness_verdict_check
  import wpsd_pkg::*;
(
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   point_valid,
  input  wire                   point_stall,
  input  wire signed [CW-1:0]   x_pos,
  input  wire signed [CW-1:0]   y_pos,
  input  wire signed [CW-1:0]   z_pos,
  input  wire                   result_valid,
  input  wire                   result_stall,
  input  wire                   steady,
  input  wire                   window_full,
  input  wire                   cfg_valid,
  input  wire                   cfg_ready,
  input  wire [MV_W-1:0]        max_variance,
  output int                    failures,
  output int                    outstanding,
  output int                    results_seen,
  output int                    steady_seen,
  output int                    full_seen,
  output int                    threshold_writes
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic steady;
    logic full;
  } stillness_t;

  // Own copy of the window, the running sums and the threshold.
  logic signed [CW-1:0]    held [WINDOW][3];
  logic signed [SUM_W:0]   axis_sum [3];
  logic [FILL_W-1:0]       held_count;
  logic [LOG_W-1:0]        next_slot;
  logic [MV_W-1:0]         threshold;

  stillness_t awaited_verdicts [$];
  int mismatch_total;
  int checked_total;
  int steady_total;
  int full_total;
  int write_total;

  // WINDOW^3 times the population variance of one axis.
  function automatic logic [63:0] axis_spread(input int a);
    logic [63:0] acc;
    logic [63:0] mag;
    longint      dev;
    acc = '0;
    for (int i = 0; i < WINDOW; i++) begin
      dev = longint'(WINDOW) * longint'(held[i][a]) - longint'(axis_sum[a]);
      mag = (dev < 0) ? -dev : dev;
      acc = acc + mag * mag;
    end
    return acc;
  endfunction

  // Takes one point into the window and works out the result it causes.
  function automatic stillness_t judge_point(input logic signed [CW-1:0] px,
                                             input logic signed [CW-1:0] py,
                                             input logic signed [CW-1:0] pz);
    logic signed [CW-1:0] p [3];
    logic [63:0]          d;
    logic [63:0]          scaled;
    logic [127:0]         total;
    logic [127:0]         limit;
    stillness_t           r;
    p[0] = px;
    p[1] = py;
    p[2] = pz;
    for (int a = 0; a < 3; a++) begin
      if (held_count >= WINDOW)
        axis_sum[a] = axis_sum[a] - held[next_slot][a];
      axis_sum[a] = axis_sum[a] + p[a];
      held[next_slot][a] = p[a];
    end
    next_slot = (next_slot == WINDOW - 1) ? '0 : next_slot + 1'b1;
    if (held_count < WINDOW)
      held_count = held_count + 1'b1;
    r.full = (held_count >= WINDOW);
    r.steady = 1'b0;
    if (r.full) begin
      scaled = 64'(threshold) * 64'(W3);
      limit = 128'(scaled) * 128'(scaled);
      total = '0;
      for (int a = 0; a < 3; a++) begin
        d = axis_spread(a);
        total = total + 128'(d) * 128'(d);
      end
      r.steady = (total < limit);
    end
    return r;
  endfunction

  always @(posedge clk) begin
    stillness_t due;
    if (rst) begin
      held_count = '0;
      next_slot = '0;
      for (int a = 0; a < 3; a++)
        axis_sum[a] = '0;
      threshold = MV_W'(MV_RESET);
      awaited_verdicts.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        threshold = max_variance;
        write_total++;
      end
      if (result_valid && !result_stall) begin
        if (awaited_verdicts.size() == 0) begin
          $display("%0t: result transfer with nothing expected (steady %0b, window_full %0b)",
                   $realtime, steady, window_full);
          mismatch_total++;
        end else begin
          due = awaited_verdicts.pop_front();
          checked_total++;
          if (due.steady !== steady) begin
            $display("%0t: steady expected %0b, actual %0b", $realtime, due.steady, steady);
            mismatch_total++;
          end
          if (due.full !== window_full) begin
            $display("%0t: window_full expected %0b, actual %0b",
                     $realtime, due.full, window_full);
            mismatch_total++;
          end
          if (due.steady)
            steady_total++;
          if (due.full)
            full_total++;
        end
      end
      if (point_valid && !point_stall)
        awaited_verdicts.push_back(judge_point(x_pos, y_pos, z_pos));
    end
    failures <= mismatch_total;
    outstanding <= awaited_verdicts.size();
    results_seen <= checked_total;
    steady_seen <= steady_total;
    full_seen <= full_total;
    threshold_writes <= write_total;
  end

endmodule

[tb/sv/windowed_position_stillness_detector_top_tb.sv]
// Testbench top for the windowed position stillness detector: clock, reset, point stimulus,
// result back-pressure and the verdict. Depends on wpsd_pkg, the block and stillness_verdict_check.

module windowed_position_stillness_detector_top_tb;
  import wpsd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COORD_MAX    = 2 ** (CW - 1) - 1;
  localparam int COORD_MIN    = -(2 ** (CW - 1));
  localparam int HOLD_CYCLES  = 200;
  localparam int LIMIT_CYCLES = 400000;

  logic                 clk;
  logic                 rst;
  logic                 point_valid;
  logic                 point_stall;
  logic signed [CW-1:0] x_pos;
  logic signed [CW-1:0] y_pos;
  logic signed [CW-1:0] z_pos;
  logic                 result_valid;
  logic                 result_stall;
  logic                 steady;
  logic                 window_full;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [MV_W-1:0]      max_variance;

  int failures;
  int outstanding;
  int results_seen;
  int steady_seen;
  int full_seen;
  int threshold_writes;

  // Idling knobs of the sender and the receiver. A hold-off is asked for by
  // bumping hold_asked; the receiver answers each request once.
  int gap_pct;
  int stall_pct;
  int hold_asked;
  int hold_given;
  int items_sent;
  int cycle_count;

  windowed_position_stillness_detector_top dut (
    .clk          (clk),
    .rst          (rst),
    .point_valid  (point_valid),
    .point_stall  (point_stall),
    .x_pos        (x_pos),
    .y_pos        (y_pos),
    .z_pos        (z_pos),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .steady       (steady),
    .window_full  (window_full),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .max_variance (max_variance)
  );

  stillness_verdict_check verdict_check (
    .clk              (clk),
    .rst              (rst),
    .point_valid      (point_valid),
    .point_stall      (point_stall),
    .x_pos            (x_pos),
    .y_pos            (y_pos),
    .z_pos            (z_pos),
    .result_valid     (result_valid),
    .result_stall     (result_stall),
    .steady           (steady),
    .window_full      (window_full),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .max_variance     (max_variance),
    .failures         (failures),
    .outstanding      (outstanding),
    .results_seen     (results_seen),
    .steady_seen      (steady_seen),
    .full_seen        (full_seen),
    .threshold_writes (threshold_writes)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // The run is cut off if it goes far beyond what the slowest correct run could take.
  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t: run did not finish within %0d cycles", $realtime, LIMIT_CYCLES);
    $display("tb: failure");
    $finish;
  end

  // Receiver. Stall comes in short random bursts, except when a long hold-off has been
  // asked for: then the result side stays blocked through the whole hold-off so that the
  // block's output register fills and the point channel backs up.
  initial begin
    result_stall <= 1'b0;
    hold_given = 0;
    forever begin
      @(posedge clk);
      if (hold_asked != hold_given) begin
        hold_given = hold_asked;
        result_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        result_stall <= 1'b0;
      end else if ($urandom_range(0, 99) < stall_pct) begin
        result_stall <= 1'b1;
        repeat ($urandom_range(1, 10)) @(posedge clk);
        result_stall <= 1'b0;
      end
    end
  end

  function automatic int clamp_coord(input int v);
    if (v > COORD_MAX)
      return COORD_MAX;
    if (v < COORD_MIN)
      return COORD_MIN;
    return v;
  endfunction

  // A coordinate that lands on the ends of the range now and then.
  function automatic int pick_coord();
    case ($urandom_range(0, 7))
      0: return COORD_MIN;
      1: return COORD_MAX;
      default: return int'($urandom_range(0, 65535)) + COORD_MIN;
    endcase
  endfunction

  // Offers one point and returns at the edge where its transfer happens. Valid stays high
  // afterwards, so back-to-back points go out without a bubble unless a gap is drawn.
  // The coordinates are expected to lie in the signed coordinate range already.
  task automatic send_point(input int px, input int py, input int pz);
    if ($urandom_range(0, 99) < gap_pct) begin
      point_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    point_valid <= 1'b1;
    x_pos <= CW'(px);
    y_pos <= CW'(py);
    z_pos <= CW'(pz);
    @(posedge clk);
    while (point_stall)
      @(posedge clk);
    items_sent++;
  endtask

  // A run of points jittered around one base point. A jitter of zero gives a window with
  // no spread at all; a large one gives a window far from steady.
  task automatic still_run(input int len, input int spread);
    int bx;
    int by;
    int bz;
    bx = pick_coord();
    by = pick_coord();
    bz = pick_coord();
    repeat (len) begin
      send_point(clamp_coord(bx + int'($urandom_range(0, 2 * spread)) - spread),
                 clamp_coord(by + int'($urandom_range(0, 2 * spread)) - spread),
                 clamp_coord(bz + int'($urandom_range(0, 2 * spread)) - spread));
    end
  endtask

  // Stops offering points and waits until every expected result has been transferred.
  // The first edge lets the checker register a transfer that happened just now.
  task automatic drain();
    point_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0)
      @(posedge clk);
  endtask

  // The threshold is only written while no point is in flight.
  task automatic set_threshold(input int v);
    drain();
    cfg_valid <= 1'b1;
    max_variance <= MV_W'(v);
    @(posedge clk);
    while (!cfg_ready)
      @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Mostly long runs that fill the window with points jittered by a random spread, some short
  // runs that break off before the window turns over, and some lone random points.
  task automatic random_mix(input int count);
    int stop_at;
    int pick;
    int spread;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      pick = $urandom_range(0, 9);
      case ($urandom_range(0, 4))
        0: spread = 0;
        1: spread = $urandom_range(1, 4);
        2: spread = $urandom_range(5, 40);
        3: spread = $urandom_range(41, 400);
        default: spread = 65535;
      endcase
      if (pick < 2)
        send_point(pick_coord(), pick_coord(), pick_coord());
      else if (pick == 2)
        still_run($urandom_range(2, 8), spread);
      else
        still_run($urandom_range(16, 32), spread);
    end
  endtask

  initial begin
    rst <= 1'b1;
    point_valid <= 1'b0;
    x_pos <= '0;
    y_pos <= '0;
    z_pos <= '0;
    cfg_valid <= 1'b0;
    max_variance <= '0;
    gap_pct = 20;
    stall_pct = 25;
    hold_asked = 0;
    items_sent = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed part at the reset threshold. The first fifteen results come while the
    // window is still filling; the sixteenth is the first with a full window, which still
    // holds the extreme points and so is not steady. Eight more identical points push the
    // extremes out, and the last one sees a window with no spread at all.
    send_point(COORD_MAX, COORD_MIN, 0);
    send_point(COORD_MIN, COORD_MAX, -1);
    send_point(0, -1, COORD_MAX);
    send_point(-1, 0, COORD_MIN);
    send_point(COORD_MAX, COORD_MAX, COORD_MAX);
    send_point(COORD_MIN, COORD_MIN, COORD_MIN);
    send_point(0, 0, 0);
    send_point(-1, -1, -1);
    repeat (16) send_point(1234, -4321, 77);

    // A zero threshold never reports steady, even for a window with no spread.
    set_threshold(0);
    still_run(20, 0);
    random_mix(20);

    // The largest threshold, against windows that swing between the ends of the range.
    set_threshold((1 << MV_W) - 1);
    for (int i = 0; i < 20; i++) begin
      if (i % 2 == 0)
        send_point(COORD_MAX, COORD_MIN, COORD_MAX);
      else
        send_point(COORD_MIN, COORD_MAX, COORD_MIN);
    end
    random_mix(20);

    // The smallest nonzero threshold, against windows with no jitter and with a jitter of one.
    set_threshold(1);
    still_run(18, 0);
    still_run(18, 1);
    random_mix(20);

    // Back at the reset value. The receiver holds off for a long stretch while points keep
    // coming with no gaps, so the block fills up and stalls its point channel.
    set_threshold(MV_RESET);
    gap_pct = 0;
    hold_asked++;
    still_run(30, 20);
    gap_pct = 20;
    random_mix(20);
    gap_pct = 0;
    stall_pct = 0;
    random_mix(20);
    gap_pct = 20;
    stall_pct = 25;

    // Thresholds in the range where near-still windows fall on either side.
    repeat (3) begin
      set_threshold(int'($urandom_range(1, 2000)));
      random_mix(20);
    end

    set_threshold(int'($urandom_range(0, 24'hFF_FFFF)));
    random_mix(20);

    // Last part with no idling on either side.
    set_threshold(MV_RESET);
    gap_pct = 0;
    stall_pct = 0;
    random_mix(40);

    drain();
    repeat (60) @(posedge clk);

    $display("Sent %0d points under %0d threshold writes; checked %0d results.",
             items_sent, threshold_writes, results_seen);
    $display("Of those, %0d had a full window and %0d were steady.", full_seen, steady_seen);
    if (failures == 0 && outstanding == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
